FILE: rtl/csp_pkg.sv
// capacity string parser package: phase type, character and unit codes,
// and the small character classification helpers
// no dependencies
package csp_pkg;

    typedef enum logic [2:0] {
        PH_INT,
        PH_FRAC,
        PH_SP1,
        PH_UNIT2,
        PH_SP2,
        PH_ERR
    } t_phase;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UC_A  = 8'h41;
    localparam logic [7:0] CH_UC_Z  = 8'h5a;
    localparam logic [7:0] CH_CASE  = 8'h20;
    localparam logic [7:0] CH_LC_B  = 8'h62;
    localparam logic [7:0] CH_LC_E  = 8'h65;
    localparam logic [7:0] CH_LC_G  = 8'h67;
    localparam logic [7:0] CH_LC_K  = 8'h6b;
    localparam logic [7:0] CH_LC_M  = 8'h6d;
    localparam logic [7:0] CH_LC_P  = 8'h70;
    localparam logic [7:0] CH_LC_T  = 8'h74;
    localparam logic [7:0] CH_LC_Y  = 8'h79;
    localparam logic [7:0] CH_LC_Z  = 8'h7a;

    localparam logic [3:0] UNIT_B  = 4'd0;
    localparam logic [3:0] UNIT_KB = 4'd1;
    localparam logic [3:0] UNIT_MB = 4'd2;
    localparam logic [3:0] UNIT_GB = 4'd3;
    localparam logic [3:0] UNIT_TB = 4'd4;
    localparam logic [3:0] UNIT_PB = 4'd5;
    localparam logic [3:0] UNIT_EB = 4'd6;
    localparam logic [3:0] UNIT_ZB = 4'd7;
    localparam logic [3:0] UNIT_YB = 4'd8;

    localparam logic [7:0] FRAC_MAX = 8'hff;

    typedef struct packed {
        t_phase     phase;
        logic [7:0] frac;
        logic [3:0] unit;
    } t_ctl;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        if (c >= CH_UC_A && c <= CH_UC_Z) begin
            return c + CH_CASE;
        end
        return c;
    endfunction

    // prefix letter of a two-letter unit, UNIT_B when none
    function automatic logic [3:0] prefix_index(input logic [7:0] lc);
        logic [3:0] idx;
        unique case (lc)
            CH_LC_K: idx = UNIT_KB;
            CH_LC_M: idx = UNIT_MB;
            CH_LC_G: idx = UNIT_GB;
            CH_LC_T: idx = UNIT_TB;
            CH_LC_P: idx = UNIT_PB;
            CH_LC_E: idx = UNIT_EB;
            CH_LC_Z: idx = UNIT_ZB;
            CH_LC_Y: idx = UNIT_YB;
            default: idx = UNIT_B;
        endcase
        return idx;
    endfunction

    function automatic t_ctl start_unit(input t_ctl c, input logic [7:0] lc);
        t_ctl       n;
        logic [3:0] idx;
        n   = c;
        idx = prefix_index(lc);
        if (lc == CH_LC_B) begin
            n.unit  = UNIT_B;
            n.phase = PH_SP2;
        end else if (idx != UNIT_B) begin
            n.unit  = idx;
            n.phase = PH_UNIT2;
        end else begin
            n.phase = PH_ERR;
        end
        return n;
    endfunction

endpackage

FILE: rtl/csp_step.sv
// capacity string parser step: next phase, fraction count, unit and
// mantissa for one non-terminator character; uses csp_pkg
module csp_step
    import csp_pkg::*;
#(
    parameter int MANTISSA_WIDTH = 64
) (
    input  logic [7:0]                i_char,
    input  t_ctl                      i_ctl,
    input  logic [MANTISSA_WIDTH-1:0] i_mant,
    output t_ctl                      o_ctl,
    output logic [MANTISSA_WIDTH-1:0] o_mant
);

    logic [7:0]                lc;
    logic                      digit;
    logic [MANTISSA_WIDTH-1:0] dval;
    logic [MANTISSA_WIDTH-1:0] mac;

    assign lc    = to_lower(i_char);
    assign digit = (i_char >= CH_ZERO) && (i_char <= CH_NINE);
    assign dval  = MANTISSA_WIDTH'(i_char[3:0]);
    // times ten plus digit, wrapping
    assign mac   = (i_mant << 3) + (i_mant << 1) + dval;

    always_comb begin
        o_ctl  = i_ctl;
        o_mant = i_mant;
        unique case (i_ctl.phase)
            PH_INT: begin
                if (digit) begin
                    o_mant = mac;
                end else if (i_char == CH_DOT) begin
                    o_ctl.phase = PH_FRAC;
                end else if (i_char == CH_SPACE) begin
                    o_ctl.phase = PH_SP1;
                end else begin
                    o_ctl = start_unit(i_ctl, lc);
                end
            end
            PH_FRAC: begin
                if (digit) begin
                    o_mant = mac;
                    if (i_ctl.frac != FRAC_MAX) begin
                        o_ctl.frac = i_ctl.frac + 8'd1;
                    end
                end else if (i_char == CH_SPACE) begin
                    o_ctl.phase = PH_SP1;
                end else begin
                    o_ctl = start_unit(i_ctl, lc);
                end
            end
            PH_SP1: begin
                if (i_char != CH_SPACE) begin
                    o_ctl = start_unit(i_ctl, lc);
                end
            end
            PH_UNIT2: begin
                o_ctl.phase = (lc == CH_LC_B) ? PH_SP2 : PH_ERR;
            end
            PH_SP2: begin
                if (i_char != CH_SPACE) begin
                    o_ctl.phase = PH_ERR;
                end
            end
            default: begin
                o_ctl.phase = PH_ERR;
            end
        endcase
    end

endmodule

FILE: rtl/capacity_string_parser_unit.sv
// capacity string parser top level: input register, parse state and
// result register; uses csp_pkg and csp_step
//
// One character is taken per transaction and a new one can be accepted in
// every cycle while o_stall is low. Each character is held in the input
// register and from there updates the parse state; the terminator byte 0
// instead loads the result register and restarts the parse, so each result
// is registered behind its terminator. Only the result register can hold
// the pipe: a terminator waits in the input register while a previous
// result is stalled, other characters always pass through.
module capacity_string_parser_unit
    import csp_pkg::*;
#(
    parameter int MANTISSA_WIDTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [7:0]                i_char_in,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [MANTISSA_WIDTH-1:0] o_mantissa,
    output logic [7:0]                o_frac_digits,
    output logic [3:0]                o_unit_index,
    output logic                      o_status
);

    logic                      r_in_valid;
    logic [7:0]                r_char;
    t_ctl                      r_ctl;
    logic [MANTISSA_WIDTH-1:0] r_mant;
    t_ctl                      n_ctl;
    logic [MANTISSA_WIDTH-1:0] n_mant;
    logic                      r_out_valid;
    logic [MANTISSA_WIDTH-1:0] r_out_mant;
    logic [7:0]                r_out_frac;
    logic [3:0]                r_out_unit;
    logic                      r_out_status;

    logic out_free;
    logic term;
    logic advance;
    logic bad;

    assign out_free = !r_out_valid || !i_stall;
    assign term     = (r_char == CH_NUL);
    assign advance  = r_in_valid && (!term || out_free);
    assign o_stall  = r_in_valid && !advance;
    assign bad      = (r_ctl.phase == PH_ERR) || (r_ctl.phase == PH_UNIT2);

    csp_step #(
        .MANTISSA_WIDTH(MANTISSA_WIDTH)
    ) u_step (
        .i_char(r_char),
        .i_ctl (r_ctl),
        .i_mant(r_mant),
        .o_ctl (n_ctl),
        .o_mant(n_mant)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_stall) begin
            r_char <= i_char_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl  <= '{phase: PH_INT, frac: '0, unit: UNIT_B};
            r_mant <= '0;
        end else if (advance) begin
            if (term) begin
                r_ctl  <= '{phase: PH_INT, frac: '0, unit: UNIT_B};
                r_mant <= '0;
            end else begin
                r_ctl  <= n_ctl;
                r_mant <= n_mant;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && term) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && term) begin
            r_out_mant   <= bad ? '0 : r_mant;
            r_out_frac   <= bad ? '0 : r_ctl.frac;
            r_out_unit   <= bad ? UNIT_B : r_ctl.unit;
            r_out_status <= bad;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_mantissa    = r_out_mant;
    assign o_frac_digits = r_out_frac;
    assign o_unit_index  = r_out_unit;
    assign o_status      = r_out_status;

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |->
            (o_mantissa == '0 && o_frac_digits == '0 && o_unit_index == UNIT_B))
        else $error("invalid result carries nonzero fields");

    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_unit_index <= UNIT_YB))
        else $error("unit index out of range");

    a_term_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && term) |=>
            (r_out_valid && r_ctl.phase == PH_INT && r_mant == '0 && r_ctl.frac == '0))
        else $error("terminator did not emit a result and restart the parse");

    a_frac_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl.phase == PH_INT) |-> (r_ctl.frac == '0 && r_ctl.unit == UNIT_B))
        else $error("fraction count or unit set during integer digits");

    a_only_term_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (term && r_out_valid && i_stall))
        else $error("input held without a stalled result ahead of a terminator");

endmodule
